// ===== src/psrl_pkg.sv =====
// ----------------------------------------------------------------------------
// psrl_pkg
// Types, constants and codes shared by the per-source rate and connection
// limiter and its memory.
// ----------------------------------------------------------------------------
`default_nettype none

package psrl_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int HISTORY_DEPTH = 128;

  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SCAN_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int HEAD_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int LEN_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int STAMP_DEPTH = TABLE_ENTRIES * HISTORY_DEPTH;
  localparam int STAMP_AW    = (STAMP_DEPTH > 1) ? $clog2(STAMP_DEPTH) : 1;

  // Operation codes
  localparam logic [1:0] FUNC_REQUEST    = 2'd0;
  localparam logic [1:0] FUNC_CONNECT    = 2'd1;
  localparam logic [1:0] FUNC_DISCONNECT = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BLOCKED = 3'd1;
  localparam logic [2:0] ST_RATE    = 3'd2;
  localparam logic [2:0] ST_CONN    = 3'd3;
  localparam logic [2:0] ST_DISC    = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_REQUESTS    = 2'd0;
  localparam logic [1:0] CFG_WINDOW_SECONDS  = 2'd1;
  localparam logic [1:0] CFG_MAX_CONNECTIONS = 2'd2;
  localparam logic [1:0] CFG_BLOCK_SECONDS   = 2'd3;

  localparam logic [7:0]  RST_MAX_REQUESTS    = 8'd100;
  localparam logic [15:0] RST_WINDOW_SECONDS  = 16'd60;
  localparam logic [15:0] RST_MAX_CONNECTIONS = 16'd10;
  localparam logic [15:0] RST_BLOCK_SECONDS   = 16'd300;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] source_address;
    logic [31:0] now_seconds;
  } item_t;

  typedef struct packed {
    logic        allowed;
    logic [2:0]  status;
    logic [15:0] observed_count;
  } result_t;

  typedef struct packed {
    logic [31:0]       address;
    logic [15:0]       conn;
    logic              blocked;
    logic [31:0]       block_start;
    logic [HEAD_W-1:0] head;
    logic [LEN_W-1:0]  len;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ===== src/per_source_rate_and_connection_limiter.sv =====
// ----------------------------------------------------------------------------
// per_source_rate_and_connection_limiter
// Sliding-window-log rate limiter and connection limiter keyed by source
// address, with the table and the timestamp rings held in RAM.
// ----------------------------------------------------------------------------
//  channel   | signals                          | transfer
//  ----------+----------------------------------+---------------------------
//  item in   | start_i, busy_o, item_i          | start_i && !busy_o
//  result    | done_o, result_o                 | done_o (one cycle)
//  config    | cfg_we_i, cfg_idx_i, cfg_data_i  | cfg_we_i
//
// An item scans the entry RAM one entry a cycle, to a hit or, for a miss, to
// the end. Table full or an unknown disconnect goes straight to the result;
// other items pass expire, decide and writeback, and an unblocked request
// also reads and checks its ring, popping each expired timestamp. busy_o
// stays high through the result strobe; the next item is taken back in idle.
// Reset clears valid bits and loads the configuration defaults, not the RAMs.
// The receiver cannot stall: done_o marks the result for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module per_source_rate_and_connection_limiter
  import psrl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire item_t       item_i,
  output logic             done_o,
  output result_t          result_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SCAN      = 3'd1;
  localparam logic [2:0] S_EXPIRE    = 3'd2;
  localparam logic [2:0] S_DECIDE    = 3'd3;
  localparam logic [2:0] S_PRUNE_RD  = 3'd4;
  localparam logic [2:0] S_PRUNE_CHK = 3'd5;
  localparam logic [2:0] S_REQ       = 3'd6;
  localparam logic [2:0] S_WB        = 3'd7;

  logic [2:0]        state_q, state_d;
  item_t             item_q, item_d;
  logic [SCAN_W-1:0] scan_q, scan_d;
  logic              rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  entry_t            ent_q, ent_d;
  logic [IDX_W-1:0]  e_q, e_d;
  result_t           res_q, res_d;
  logic              wb_q, wb_d;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;

  logic [7:0]  max_req_q;
  logic [15:0] window_q, max_conn_q, block_q;

  // RAM ports
  logic             ent_re;
  logic [IDX_W-1:0] ent_raddr;
  entry_t           ent_rdata;
  logic [ENTRY_W-1:0] ent_rdata_raw;
  logic             ent_we;
  logic             st_re, st_we;
  logic [STAMP_AW-1:0] st_raddr, st_waddr;
  logic [31:0]      st_rdata;

  // First free entry
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  logic [31:0]       age;
  logic [15:0]       limit;
  logic [LEN_W:0]    tail_sum;
  logic [HEAD_W-1:0] tail;

  assign ent_rdata = entry_t'(ent_rdata_raw);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    item_d   = item_q;
    scan_d   = scan_q;
    rd_vld_d = 1'b0;
    rd_idx_d = rd_idx_q;
    ent_d    = ent_q;
    e_d      = e_q;
    res_d    = res_q;
    wb_d     = wb_q;
    valid_d  = valid_q;

    ent_re    = 1'b0;
    ent_raddr = scan_q[IDX_W-1:0];
    ent_we    = 1'b0;
    st_re     = 1'b0;
    st_we     = 1'b0;
    st_raddr  = STAMP_AW'(e_q * HISTORY_DEPTH) + STAMP_AW'(ent_q.head);
    tail_sum  = (LEN_W+1)'(ent_q.head) + (LEN_W+1)'(ent_q.len);
    tail      = (tail_sum >= (LEN_W+1)'(HISTORY_DEPTH))
              ? HEAD_W'(tail_sum - (LEN_W+1)'(HISTORY_DEPTH)) : HEAD_W'(tail_sum);
    st_waddr  = STAMP_AW'(e_q * HISTORY_DEPTH) + STAMP_AW'(tail);
    age       = 32'h0;
    limit     = (max_req_q < 8'(HISTORY_DEPTH > 255 ? 255 : HISTORY_DEPTH)
                 || HISTORY_DEPTH > 255)
              ? {8'h00, max_req_q} : 16'(HISTORY_DEPTH);

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          item_d   = item_i;
          scan_d   = '0;
          state_d  = S_SCAN;
        end
      end

      S_SCAN: begin
        if (scan_q < SCAN_W'(TABLE_ENTRIES)) begin
          ent_re   = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = scan_q[IDX_W-1:0];
          scan_d   = scan_q + SCAN_W'(1);
        end
        if (rd_vld_q && valid_q[rd_idx_q]
            && ent_rdata.address == item_q.source_address) begin
          e_d      = rd_idx_q;
          ent_d    = ent_rdata;
          wb_d     = 1'b1;
          rd_vld_d = 1'b0;
          state_d  = S_EXPIRE;
        end else if (!rd_vld_q && scan_q == SCAN_W'(TABLE_ENTRIES)) begin
          if (!item_q.func[1]) begin
            if (free_found) begin
              e_d               = free_idx;
              ent_d.address     = item_q.source_address;
              ent_d.conn        = '0;
              ent_d.blocked     = 1'b0;
              ent_d.block_start = '0;
              ent_d.head        = '0;
              ent_d.len         = '0;
              wb_d              = 1'b1;
              state_d           = S_EXPIRE;
            end else begin
              res_d   = '{allowed: 1'b0, status: ST_FULL, observed_count: 16'h0};
              wb_d    = 1'b0;
              state_d = S_WB;
            end
          end else begin
            res_d   = '{allowed: 1'b0, status: ST_DISC, observed_count: 16'h0};
            wb_d    = 1'b0;
            state_d = S_WB;
          end
        end
      end

      S_EXPIRE: begin
        age = item_q.now_seconds - ent_q.block_start;
        if (ent_q.blocked && age >= {16'h0, block_q}) begin
          ent_d.blocked = 1'b0;
        end
        state_d = S_DECIDE;
      end

      S_DECIDE: begin
        if (!item_q.func[1] && ent_q.blocked) begin
          res_d.allowed        = 1'b0;
          res_d.status         = ST_BLOCKED;
          res_d.observed_count = (item_q.func == FUNC_REQUEST)
                               ? 16'(ent_q.len) : ent_q.conn;
          state_d = S_WB;
        end else if (item_q.func == FUNC_REQUEST) begin
          state_d = S_PRUNE_RD;
        end else if (item_q.func == FUNC_CONNECT) begin
          if (ent_q.conn >= max_conn_q) begin
            ent_d.blocked     = 1'b1;
            ent_d.block_start = item_q.now_seconds;
            res_d = '{allowed: 1'b0, status: ST_CONN, observed_count: ent_q.conn};
          end else begin
            ent_d.conn = ent_q.conn + 16'd1;
            res_d = '{allowed: 1'b1, status: ST_OK, observed_count: ent_q.conn + 16'd1};
          end
          state_d = S_WB;
        end else begin
          // Disconnect, also for the unused operation code
          if (ent_q.conn != 16'h0) begin
            ent_d.conn = ent_q.conn - 16'd1;
          end
          res_d.allowed        = 1'b0;
          res_d.status         = ST_DISC;
          res_d.observed_count = ent_d.conn;
          state_d = S_WB;
        end
      end

      S_PRUNE_RD: begin
        if (ent_q.len == '0) begin
          state_d = S_REQ;
        end else begin
          st_re   = 1'b1;
          state_d = S_PRUNE_CHK;
        end
      end

      S_PRUNE_CHK: begin
        age = item_q.now_seconds - st_rdata;
        if (age > {16'h0, window_q}) begin
          // Drop the oldest stamp
          ent_d.head = (ent_q.head == HEAD_W'(HISTORY_DEPTH - 1))
                     ? '0 : ent_q.head + HEAD_W'(1);
          ent_d.len  = ent_q.len - LEN_W'(1);
          state_d    = S_PRUNE_RD;
        end else begin
          state_d = S_REQ;
        end
      end

      S_REQ: begin
        if (16'(ent_q.len) >= limit) begin
          ent_d.blocked     = 1'b1;
          ent_d.block_start = item_q.now_seconds;
          res_d = '{allowed: 1'b0, status: ST_RATE, observed_count: 16'(ent_q.len)};
        end else begin
          st_we     = 1'b1;
          ent_d.len = ent_q.len + LEN_W'(1);
          res_d = '{allowed: 1'b1, status: ST_OK,
                    observed_count: 16'(ent_q.len) + 16'd1};
        end
        state_d = S_WB;
      end

      S_WB: begin
        if (wb_q) begin
          ent_we        = 1'b1;
          valid_d[e_q]  = !(ent_q.len == '0 && ent_q.conn == 16'h0 && !ent_q.blocked);
        end
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rd_vld_q   <= 1'b0;
      valid_q    <= '0;
      max_req_q  <= RST_MAX_REQUESTS;
      window_q   <= RST_WINDOW_SECONDS;
      max_conn_q <= RST_MAX_CONNECTIONS;
      block_q    <= RST_BLOCK_SECONDS;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_vld_d;
      valid_q  <= valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MAX_REQUESTS:    max_req_q  <= cfg_data_i[7:0];
          CFG_WINDOW_SECONDS:  window_q   <= cfg_data_i;
          CFG_MAX_CONNECTIONS: max_conn_q <= cfg_data_i;
          CFG_BLOCK_SECONDS:   block_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    scan_q   <= scan_d;
    rd_idx_q <= rd_idx_d;
    ent_q    <= ent_d;
    e_q      <= e_d;
    res_q    <= res_d;
    wb_q     <= wb_d;
  end

  psrl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (e_q),
    .wdata_i (ENTRY_W'(ent_q)),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata_raw)
  );

  psrl_ram #(
    .WIDTH (32),
    .DEPTH (STAMP_DEPTH)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (item_q.now_seconds),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = (state_q == S_WB);
  assign result_o = res_q;

`ifndef SYNTH
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result strobe outside an item");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
  a_allowed_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.allowed) |-> (result_o.status == ST_OK))
    else $error("admitted item with a denial status");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accepted item not taken up");
`endif

endmodule

`default_nettype wire

// ===== src/psrl_ram.sv =====
// ----------------------------------------------------------------------------
// psrl_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module psrl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== test/per_source_rate_and_connection_limiter_tb.sv =====
// ----------------------------------------------------------------------------
// per_source_rate_and_connection_limiter_tb
// Drives request, connect and disconnect commands from a pool of source
// addresses through several limit settings, predicts every result with a
// software copy of the source table and compares each result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module per_source_rate_and_connection_limiter_tb;
  import psrl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  item_t       item_i = '0;
  logic        done_o;
  result_t     result_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  per_source_rate_and_connection_limiter DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .item_i, .done_o, .result_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end

  // Limiter settings and source table as the block should hold them
  int unsigned lim_requests, lim_window, lim_conns, lim_block;
  bit          src_valid [TABLE_ENTRIES];
  logic [31:0] src_addr [TABLE_ENTRIES];
  int unsigned src_conns [TABLE_ENTRIES];
  bit          src_blocked [TABLE_ENTRIES];
  logic [31:0] src_block_at [TABLE_ENTRIES];
  int unsigned src_head [TABLE_ENTRIES];
  int unsigned src_len [TABLE_ENTRIES];
  logic [31:0] src_stamps [TABLE_ENTRIES][HISTORY_DEPTH];

  // Expected results in transfer order, written by the sender, read by the checker
  result_t     verdict_fifo [256];
  int unsigned verdict_wr = 0;
  int unsigned verdict_rd = 0;
  int          errors = 0;
  int          send_idle_pct = 0;
  logic [31:0] clock_secs = '0;
  logic [31:0] addr_pool [80];

  task automatic report(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int lookup_source(logic [31:0] a);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (src_valid[i] && src_addr[i] == a) return i;
    return -1;
  endfunction

  function automatic result_t judge_item(item_t it);
    result_t     r;
    int          e;
    int unsigned lim;
    logic [31:0] now;
    now = it.now_seconds;
    r.allowed = 1'b0;
    r.status = ST_DISC;
    r.observed_count = '0;
    e = lookup_source(it.source_address);
    if (e < 0 && (it.func == FUNC_REQUEST || it.func == FUNC_CONNECT)) begin
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (!src_valid[i]) begin
          e = i;
          break;
        end
      if (e < 0) begin
        r.status = ST_FULL;
        return r;
      end
      src_valid[e] = 1'b1;
      src_addr[e] = it.source_address;
      src_conns[e] = 0;
      src_blocked[e] = 1'b0;
      src_block_at[e] = '0;
      src_head[e] = 0;
      src_len[e] = 0;
    end
    if (e < 0) return r;
    if (src_blocked[e] && 32'(now - src_block_at[e]) >= lim_block) src_blocked[e] = 1'b0;
    if ((it.func == FUNC_REQUEST || it.func == FUNC_CONNECT) && src_blocked[e]) begin
      r.status = ST_BLOCKED;
      r.observed_count = 16'(it.func == FUNC_REQUEST ? src_len[e] : src_conns[e]);
    end else if (it.func == FUNC_REQUEST) begin
      lim = lim_requests < HISTORY_DEPTH ? lim_requests : HISTORY_DEPTH;
      // drop stamps that fell out of the window
      while (src_len[e] > 0 && 32'(now - src_stamps[e][src_head[e]]) > lim_window) begin
        src_head[e] = (src_head[e] + 1) % HISTORY_DEPTH;
        src_len[e]--;
      end
      if (src_len[e] >= lim) begin
        src_blocked[e] = 1'b1;
        src_block_at[e] = now;
        r.status = ST_RATE;
      end else begin
        src_stamps[e][(src_head[e] + src_len[e]) % HISTORY_DEPTH] = now;
        src_len[e]++;
        r.allowed = 1'b1;
        r.status = ST_OK;
      end
      r.observed_count = 16'(src_len[e]);
    end else if (it.func == FUNC_CONNECT) begin
      if (src_conns[e] >= lim_conns) begin
        src_blocked[e] = 1'b1;
        src_block_at[e] = now;
        r.status = ST_CONN;
      end else begin
        src_conns[e]++;
        r.allowed = 1'b1;
        r.status = ST_OK;
      end
      r.observed_count = 16'(src_conns[e]);
    end else begin
      if (src_conns[e] > 0) src_conns[e]--;
      r.observed_count = 16'(src_conns[e]);
    end
    if (src_len[e] == 0 && src_conns[e] == 0 && !src_blocked[e]) src_valid[e] = 1'b0;
    return r;
  endfunction

  // Check each result strobe against the oldest pending verdict
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o) begin
      if (verdict_wr == verdict_rd) begin
        report("unexpected result, status", result_o.status, -1);
      end else begin
        want = verdict_fifo[verdict_rd % 256];
        verdict_rd++;
        if (result_o.allowed !== want.allowed)
          report("allowed", result_o.allowed, want.allowed);
        if (result_o.status !== want.status)
          report("status", result_o.status, want.status);
        if (result_o.observed_count !== want.observed_count)
          report("observed_count", result_o.observed_count, want.observed_count);
      end
    end
  end

  // Hold start until the transfer; leave start high for a back-to-back item
  task automatic send_item(logic [1:0] f, logic [31:0] a, logic [31:0] t);
    item_t it;
    it.func = f;
    it.source_address = a;
    it.now_seconds = t;
    start_i <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    verdict_fifo[verdict_wr % 256] = judge_item(it);
    verdict_wr++;
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    start_i <= 1'b0;
    while (verdict_wr != verdict_rd) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= 16'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MAX_REQUESTS:    lim_requests = val & 8'hFF;
      CFG_WINDOW_SECONDS:  lim_window = val & 16'hFFFF;
      CFG_MAX_CONNECTIONS: lim_conns = val & 16'hFFFF;
      default:             lim_block = val & 16'hFFFF;
    endcase
  endtask

  task automatic set_limits(int unsigned mr, int unsigned win, int unsigned mc, int unsigned bs);
    write_reg(CFG_MAX_REQUESTS, mr);
    write_reg(CFG_WINDOW_SECONDS, win);
    write_reg(CFG_MAX_CONNECTIONS, mc);
    write_reg(CFG_BLOCK_SECONDS, bs);
  endtask

  // Free every entry: a zero request limit blocks with an empty history,
  // then disconnects after expiry release the entry.
  task automatic flush_table;
    logic [31:0] a;
    set_limits(0, 0, 0, 1);
    clock_secs += 32'd70000;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (src_valid[i]) begin
        a = src_addr[i];
        send_item(FUNC_REQUEST, a, clock_secs);
        while (src_valid[i] && src_addr[i] == a)
          send_item(FUNC_DISCONNECT, a, clock_secs + 32'd1);
      end
    end
    clock_secs += 32'd2;
    drain();
  endtask

  task automatic test_directed;
    logic [31:0] a, b;
    a = 32'h0A00_0001;
    b = 32'hC0A8_0101;
    send_item(FUNC_REQUEST, a, 32'd0);
    send_item(FUNC_CONNECT, a, 32'd1);
    send_item(FUNC_DISCONNECT, a, 32'd1);
    send_item(2'd3, a, 32'd2);
    send_item(FUNC_DISCONNECT, b, 32'd2);
    send_item(FUNC_REQUEST, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(FUNC_REQUEST, 32'hFFFF_FFFF, 32'd0);
    send_item(FUNC_REQUEST, 32'h0, 32'd5);
    set_limits(1, 60, 0, 1);
    send_item(FUNC_REQUEST, b, 32'd10);
    send_item(FUNC_REQUEST, b, 32'd10);
    send_item(FUNC_REQUEST, b, 32'd10);
    send_item(FUNC_REQUEST, b, 32'd11);
    send_item(FUNC_CONNECT, a, 32'd20);
    send_item(FUNC_CONNECT, a, 32'd20);
    send_item(FUNC_CONNECT, a, 32'd21);
    set_limits(0, 0, 1, 65535);
    send_item(FUNC_REQUEST, a, 32'd30);
    send_item(FUNC_REQUEST, a, 32'd31);
    send_item(FUNC_CONNECT, 32'h1234_5678, 32'd32);
    send_item(FUNC_DISCONNECT, 32'h1234_5678, 32'd33);
    clock_secs = 32'd100;
    flush_table();
  endtask

  // Fill the stamp ring past its depth with a request limit above it
  task automatic test_ring_limit;
    set_limits(255, 65535, 65535, 5);
    for (int i = 0; i < HISTORY_DEPTH + 3; i++)
      send_item(FUNC_REQUEST, 32'h5555_AAAA, clock_secs);
    clock_secs += 32'd10;
    send_item(FUNC_REQUEST, 32'h5555_AAAA, clock_secs);
    flush_table();
  endtask

  task automatic test_table_full;
    set_limits(128, 65535, 10, 300);
    for (int i = 0; i < TABLE_ENTRIES + 3; i++)
      send_item(i[0] ? FUNC_CONNECT : FUNC_REQUEST, 32'hAC10_0000 + i, clock_secs);
    send_item(FUNC_DISCONNECT, 32'hDEAD_BEEF, clock_secs);
    flush_table();
  endtask

  task automatic run_phase(int k, int n);
    int          r, pool_n;
    logic [1:0]  f;
    logic [31:0] a;
    case (k % 3)
      0: set_limits(1, 0, 0, 1);
      1: set_limits(128, 65535, 65535, 65535);
      default: set_limits($urandom_range(0, 10), $urandom_range(0, 30),
                          $urandom_range(0, 12), $urandom_range(1, 40));
    endcase
    pool_n = (k == 5) ? 80 : $urandom_range(2, 40);
    for (int i = 0; i < pool_n; i++) addr_pool[i] = $urandom;
    clock_secs = $urandom;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      f = r < 45 ? FUNC_REQUEST : r < 75 ? FUNC_CONNECT : r < 97 ? FUNC_DISCONNECT : 2'd3;
      a = ($urandom_range(0, 99) < 3) ? $urandom : addr_pool[$urandom_range(0, pool_n - 1)];
      if ($urandom_range(0, 99) < 3) clock_secs += $urandom_range(0, 100000);
      else clock_secs += $urandom_range(0, 2);
      send_item(f, a, clock_secs);
    end
    flush_table();
  endtask

  task automatic test_random;
    int pcts [3] = '{27, 73, 0};
    for (int k = 0; k < 9; k++) begin
      send_idle_pct = pcts[k / 3];
      run_phase(k, 190);
    end
    send_idle_pct = 0;
  endtask

  initial begin
    lim_requests = RST_MAX_REQUESTS;
    lim_window = RST_WINDOW_SECONDS;
    lim_conns = RST_MAX_CONNECTIONS;
    lim_block = RST_BLOCK_SECONDS;
    for (int i = 0; i < TABLE_ENTRIES; i++) src_valid[i] = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 27;
    test_directed();
    test_ring_limit();
    test_table_full();
    test_random();
    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
